### rtl/core/pinned_lru_page_buffer_pool_defines.svh
// assertion macros shared by the buffer pool checker
// depends on signals aclk and aresetn being visible where a macro is used
`ifndef PINNED_LRU_PAGE_BUFFER_POOL_DEFINES_SVH
`define PINNED_LRU_PAGE_BUFFER_POOL_DEFINES_SVH

// property that must hold in the same cycle as its antecedent
`define PLBP_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its antecedent
`define PLBP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/plbp_pkg.sv
// shared codes and field widths of the pinned lru page buffer pool
// no dependencies
package plbp_pkg;

    localparam int ACTION_W = 3;
    localparam int FILE_W   = 10;
    localparam int PAGE_W   = 24;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    // operation codes
    localparam logic [ACTION_W-1:0] ACT_FETCH_PIN  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOCATE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MARK_DIRTY = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UNPIN      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FLUSH_FILE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_FORCE_WB   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_RESIDENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PINNED_CONFL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_PINNED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_VICTIM      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FLUSH_PINNED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ALREADY_RESID  = 3'd6;

endpackage

### rtl/core/pinned_lru_page_buffer_pool.sv
// Pinned LRU page buffer pool: slot table, recency and free orders, walking sequencer.
// Depends on plbp_pkg.
//
// Usage: one operation item enters on the s_axis channel (fetch with pin, allocate,
// mark dirty, unpin, flush a file, force write-back). Each item yields one or more
// result items on the m_axis channel; tlast marks the final result of the item.
// Write-back requests for dirty pages ride on the results, reads are requested
// through fetch_needed. Page data never passes through the block.
// Timing: s_axis_tready is high only while the sequencer is idle. A tag lookup
// steps through the slots one per cycle with a single comparator, a victim
// search then scans all POOL_SLOTS slots, a flush walks up to POOL_SLOTS slots
// and a forced write-back walks the recency order one position per cycle; both
// walks hold on a result while the output register is still full.
// A single output register holds the current result; when the receiver stalls,
// the sequencer waits on the next result, and a new item may be accepted while
// the final result still waits in that register.
// Reset (aresetn low, synchronous) empties the pool: no slot valid, no pins,
// recency order empty, free order holding slots 0 upward.
module pinned_lru_page_buffer_pool #(
    parameter int POOL_SLOTS = 16,
    parameter int MAX_PINS   = 255
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // action[2:0], file_id[12:3], page_number[36:13], all_pages[37],
    // allow_shared_pin[38], zero[39]
    input  logic [plbp_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[2:0], slot_index[6:3], fetch_needed[7], writeback_valid[8],
    // writeback_file[18:9], writeback_page[42:19], writeback_slot[46:43], zero[47]
    output logic [plbp_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int PIN_W = (MAX_PINS > 1) ? $clog2(MAX_PINS + 1) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);
    localparam logic [PIN_W-1:0] PIN_MAX  = PIN_W'(MAX_PINS);
    localparam logic [PIN_W-1:0] PIN_ONE  = PIN_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_SLOTS);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOOKUP = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_VICTIM = 8'b0000_1000,
        S_VINST  = 8'b0001_0000,
        S_FLUSH  = 8'b0010_0000,
        S_FORCE  = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    // sequencer and operation registers
    state_t state_reg, state_next;
    logic [plbp_pkg::ACTION_W-1:0] action_reg, action_next;
    logic [plbp_pkg::FILE_W-1:0]   file_reg, file_next;
    logic [plbp_pkg::PAGE_W-1:0]   page_reg, page_next;
    logic all_reg, all_next, shared_reg, shared_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic hit_reg, hit_next;
    logic [IDX_W-1:0] hit_slot_reg, hit_slot_next;
    logic best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_slot_reg, best_slot_next;
    logic [IDX_W-1:0] best_pos_reg, best_pos_next;

    // slot table
    logic                        valid_reg [POOL_SLOTS];
    logic                        valid_next [POOL_SLOTS];
    logic [plbp_pkg::FILE_W-1:0] sfile_reg [POOL_SLOTS];
    logic [plbp_pkg::FILE_W-1:0] sfile_next [POOL_SLOTS];
    logic [plbp_pkg::PAGE_W-1:0] spage_reg [POOL_SLOTS];
    logic [plbp_pkg::PAGE_W-1:0] spage_next [POOL_SLOTS];
    logic [PIN_W-1:0]            pins_reg [POOL_SLOTS];
    logic [PIN_W-1:0]            pins_next [POOL_SLOTS];
    logic                        dirty_reg [POOL_SLOTS];
    logic                        dirty_next [POOL_SLOTS];

    // recency and free orders kept as a position per slot
    logic             in_rec_reg [POOL_SLOTS];
    logic             in_rec_next [POOL_SLOTS];
    logic [IDX_W-1:0] rec_pos_reg [POOL_SLOTS];
    logic [IDX_W-1:0] rec_pos_next [POOL_SLOTS];
    logic             in_free_reg [POOL_SLOTS];
    logic             in_free_next [POOL_SLOTS];
    logic [IDX_W-1:0] free_pos_reg [POOL_SLOTS];
    logic [IDX_W-1:0] free_pos_next [POOL_SLOTS];
    logic [CNT_W-1:0] rec_cnt_reg, rec_cnt_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;

    // output register
    logic m_valid_reg, m_valid_next;
    logic [plbp_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic m_last_reg, m_last_next;

    // list operation requests
    logic rf_en, rr_en, ff_en, ft_en;
    logic [IDX_W-1:0] rf_slot, rr_slot, ff_slot;

    // result being emitted
    logic emit;
    logic [plbp_pkg::STATUS_W-1:0] o_status;
    logic [IDX_W-1:0] o_slot, o_wbs;
    logic o_fetch, o_wbv, o_last;
    logic [plbp_pkg::FILE_W-1:0] o_wbf;
    logic [plbp_pkg::PAGE_W-1:0] o_wbp;

    logic out_free;
    logic s_accept;
    logic [IDX_W-1:0] free_front_slot, rec_at_k_slot;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // slot at the front of the free order, slot at recency position k
    always_comb begin
        free_front_slot = '0;
        rec_at_k_slot   = '0;
        for (int j = 0; j < POOL_SLOTS; j++) begin
            if (in_free_reg[j] && free_pos_reg[j] == '0) begin
                free_front_slot = IDX_W'(j);
            end
            if (in_rec_reg[j] && rec_pos_reg[j] == k_reg[IDX_W-1:0]) begin
                rec_at_k_slot = IDX_W'(j);
            end
        end
    end

    // sequencer
    always_comb begin
        logic fmatch;
        logic [IDX_W-1:0] s;
        state_next      = state_reg;
        action_next     = action_reg;
        file_next       = file_reg;
        page_next       = page_reg;
        all_next        = all_reg;
        shared_next     = shared_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_pos_next   = best_pos_reg;
        valid_next      = valid_reg;
        sfile_next      = sfile_reg;
        spage_next      = spage_reg;
        pins_next       = pins_reg;
        dirty_next      = dirty_reg;
        rf_en = 1'b0; rr_en = 1'b0; ff_en = 1'b0; ft_en = 1'b0;
        rf_slot = '0; rr_slot = '0; ff_slot = '0;
        emit = 1'b0;
        o_status = plbp_pkg::ST_OK;
        o_slot = '0; o_wbs = '0; o_fetch = 1'b0; o_wbv = 1'b0; o_last = 1'b1;
        o_wbf = '0; o_wbp = '0;
        fmatch = 1'b0;
        s = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    action_next = s_axis_tdata[2:0];
                    file_next   = s_axis_tdata[12:3];
                    page_next   = s_axis_tdata[36:13];
                    all_next    = s_axis_tdata[37];
                    shared_next = s_axis_tdata[38];
                    idx_next    = '0;
                    k_next      = '0;
                    hit_next    = 1'b0;
                    priority if (s_axis_tdata[2:0] == plbp_pkg::ACT_FLUSH_FILE) begin
                        state_next = S_FLUSH;
                    end else if (s_axis_tdata[2:0] == plbp_pkg::ACT_FORCE_WB) begin
                        state_next = S_FORCE;
                    end else if (s_axis_tdata[2:0] <= plbp_pkg::ACT_UNPIN) begin
                        state_next = S_LOOKUP;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end
            end
            // one tag compare per cycle
            S_LOOKUP: begin
                if (valid_reg[idx_reg] && sfile_reg[idx_reg] == file_reg
                        && spage_reg[idx_reg] == page_reg) begin
                    hit_next      = 1'b1;
                    hit_slot_next = idx_reg;
                    state_next    = S_DECIDE;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = S_DECIDE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    s = hit_slot_reg;
                    state_next = S_IDLE;
                    emit = 1'b1;
                    unique case (action_reg)
                        plbp_pkg::ACT_FETCH_PIN, plbp_pkg::ACT_ALLOCATE: begin
                            if (hit_reg) begin
                                o_slot = s;
                                if (action_reg == plbp_pkg::ACT_ALLOCATE) begin
                                    o_status = plbp_pkg::ST_ALREADY_RESID;
                                end else if (!shared_reg && pins_reg[s] != '0) begin
                                    o_status = plbp_pkg::ST_PINNED_CONFL;
                                end else begin
                                    if (pins_reg[s] < PIN_MAX) begin
                                        pins_next[s] = pins_reg[s] + 1'b1;
                                    end
                                    rf_en = 1'b1; rf_slot = s;
                                end
                            end else if (free_cnt_reg != '0) begin
                                // new page takes the front free slot
                                s = free_front_slot;
                                ft_en = 1'b1;
                                rf_en = 1'b1; rf_slot = s;
                                valid_next[s] = 1'b1;
                                sfile_next[s] = file_reg;
                                spage_next[s] = page_reg;
                                pins_next[s]  = PIN_ONE;
                                dirty_next[s] = 1'b0;
                                o_slot  = s;
                                o_fetch = (action_reg == plbp_pkg::ACT_FETCH_PIN);
                            end else begin
                                emit = 1'b0;
                                idx_next = '0;
                                best_found_next = 1'b0;
                                state_next = S_VICTIM;
                            end
                        end
                        plbp_pkg::ACT_MARK_DIRTY: begin
                            if (!hit_reg) begin
                                o_status = plbp_pkg::ST_NOT_RESIDENT;
                            end else begin
                                dirty_next[s] = 1'b1;
                                rf_en = 1'b1; rf_slot = s;
                                o_slot = s;
                            end
                        end
                        plbp_pkg::ACT_UNPIN: begin
                            if (!hit_reg) begin
                                o_status = plbp_pkg::ST_NOT_RESIDENT;
                            end else if (pins_reg[s] == '0) begin
                                o_status = plbp_pkg::ST_NOT_PINNED;
                                o_slot = s;
                            end else begin
                                pins_next[s] = pins_reg[s] - 1'b1;
                                if (pins_reg[s] == PIN_ONE) begin
                                    rf_en = 1'b1; rf_slot = s;
                                end
                                o_slot = s;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // least recent unpinned slot: largest recency position with no pins
            S_VICTIM: begin
                if (in_rec_reg[idx_reg] && pins_reg[idx_reg] == '0
                        && (!best_found_reg || rec_pos_reg[idx_reg] > best_pos_reg)) begin
                    best_found_next = 1'b1;
                    best_slot_next  = idx_reg;
                    best_pos_next   = rec_pos_reg[idx_reg];
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = S_VINST;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_VINST: begin
                if (out_free) begin
                    emit = 1'b1;
                    state_next = S_IDLE;
                    if (!best_found_reg) begin
                        o_status = plbp_pkg::ST_NO_VICTIM;
                    end else begin
                        s = best_slot_reg;
                        if (valid_reg[s] && dirty_reg[s]) begin
                            o_wbv = 1'b1;
                            o_wbf = sfile_reg[s];
                            o_wbp = spage_reg[s];
                            o_wbs = s;
                        end
                        rf_en = 1'b1; rf_slot = s;
                        valid_next[s] = 1'b1;
                        sfile_next[s] = file_reg;
                        spage_next[s] = page_reg;
                        pins_next[s]  = PIN_ONE;
                        dirty_next[s] = 1'b0;
                        o_slot  = s;
                        o_fetch = (action_reg == plbp_pkg::ACT_FETCH_PIN);
                    end
                end
            end
            // walk slots by index, freeing those of the file; a pinned slot of the file ends the walk
            S_FLUSH: begin
                s = idx_reg;
                fmatch = valid_reg[s] && sfile_reg[s] == file_reg;
                if (!fmatch) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FIN;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else if (pins_reg[s] != '0) begin
                    if (out_free) begin
                        emit = 1'b1;
                        o_status = plbp_pkg::ST_FLUSH_PINNED;
                        o_slot = s;
                        state_next = S_IDLE;
                    end
                end else if (!dirty_reg[s] || out_free) begin
                    if (dirty_reg[s]) begin
                        emit = 1'b1;
                        o_slot = s;
                        o_wbv = 1'b1;
                        o_wbf = sfile_reg[s];
                        o_wbp = spage_reg[s];
                        o_wbs = s;
                        o_last = 1'b0;
                    end
                    dirty_next[s] = 1'b0;
                    valid_next[s] = 1'b0;
                    rr_en = 1'b1; rr_slot = s;
                    ff_en = 1'b1; ff_slot = s;
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FIN;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            // walk the recency order, most recent first
            S_FORCE: begin
                if (k_reg == rec_cnt_reg) begin
                    state_next = S_FIN;
                end else begin
                    s = rec_at_k_slot;
                    fmatch = valid_reg[s] && sfile_reg[s] == file_reg
                        && (all_reg || spage_reg[s] == page_reg) && dirty_reg[s];
                    if (!fmatch) begin
                        k_next = k_reg + 1'b1;
                    end else if (out_free) begin
                        emit = 1'b1;
                        o_slot = s;
                        o_wbv = 1'b1;
                        o_wbf = sfile_reg[s];
                        o_wbp = spage_reg[s];
                        o_wbs = s;
                        o_last = 1'b0;
                        dirty_next[s] = 1'b0;
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // list updates
    always_comb begin
        in_rec_next   = in_rec_reg;
        rec_pos_next  = rec_pos_reg;
        in_free_next  = in_free_reg;
        free_pos_next = free_pos_reg;
        rec_cnt_next  = rec_cnt_reg;
        free_cnt_next = free_cnt_reg;
        // remove from the recency order
        if (rr_en && in_rec_reg[rr_slot]) begin
            for (int j = 0; j < POOL_SLOTS; j++) begin
                if (in_rec_reg[j] && rec_pos_reg[j] > rec_pos_reg[rr_slot]) begin
                    rec_pos_next[j] = rec_pos_reg[j] - 1'b1;
                end
            end
            in_rec_next[rr_slot] = 1'b0;
            rec_cnt_next = rec_cnt_reg - 1'b1;
        end
        // move to the front of the recency order
        if (rf_en) begin
            for (int j = 0; j < POOL_SLOTS; j++) begin
                if (in_rec_reg[j] && (!in_rec_reg[rf_slot]
                        || rec_pos_reg[j] < rec_pos_reg[rf_slot])) begin
                    rec_pos_next[j] = rec_pos_reg[j] + 1'b1;
                end
            end
            if (!in_rec_reg[rf_slot]) begin
                rec_cnt_next = rec_cnt_reg + 1'b1;
            end
            in_rec_next[rf_slot]  = 1'b1;
            rec_pos_next[rf_slot] = '0;
        end
        // take the front of the free order
        if (ft_en) begin
            for (int j = 0; j < POOL_SLOTS; j++) begin
                if (in_free_reg[j]) begin
                    if (free_pos_reg[j] == '0) begin
                        in_free_next[j] = 1'b0;
                    end else begin
                        free_pos_next[j] = free_pos_reg[j] - 1'b1;
                    end
                end
            end
            free_cnt_next = free_cnt_reg - 1'b1;
        end
        // put at the front of the free order
        if (ff_en && free_cnt_reg < CNT_FULL) begin
            for (int j = 0; j < POOL_SLOTS; j++) begin
                if (in_free_reg[j]) begin
                    free_pos_next[j] = free_pos_reg[j] + 1'b1;
                end
            end
            in_free_next[ff_slot]  = 1'b1;
            free_pos_next[ff_slot] = '0;
            free_cnt_next = free_cnt_reg + 1'b1;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, plbp_pkg::SLOT_W'(o_wbs), o_wbp, o_wbf, o_wbv, o_fetch,
                            plbp_pkg::SLOT_W'(o_slot), o_status};
            m_last_next  = o_last;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            rec_cnt_reg  <= '0;
            free_cnt_reg <= CNT_FULL;
            for (int j = 0; j < POOL_SLOTS; j++) begin
                valid_reg[j]    <= 1'b0;
                pins_reg[j]     <= '0;
                dirty_reg[j]    <= 1'b0;
                in_rec_reg[j]   <= 1'b0;
                rec_pos_reg[j]  <= '0;
                in_free_reg[j]  <= 1'b1;
                free_pos_reg[j] <= IDX_W'(j);
            end
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            rec_cnt_reg  <= rec_cnt_next;
            free_cnt_reg <= free_cnt_next;
            valid_reg    <= valid_next;
            pins_reg     <= pins_next;
            dirty_reg    <= dirty_next;
            in_rec_reg   <= in_rec_next;
            rec_pos_reg  <= rec_pos_next;
            in_free_reg  <= in_free_next;
            free_pos_reg <= free_pos_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        action_reg     <= action_next;
        file_reg       <= file_next;
        page_reg       <= page_next;
        all_reg        <= all_next;
        shared_reg     <= shared_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        hit_reg        <= hit_next;
        hit_slot_reg   <= hit_slot_next;
        best_found_reg <= best_found_next;
        best_slot_reg  <= best_slot_next;
        best_pos_reg   <= best_pos_next;
        sfile_reg      <= sfile_next;
        spage_reg      <= spage_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

endmodule

### rtl/core/plbp_checker.sv
// port-level checks for the pinned lru page buffer pool, bound to the top level
// depends on plbp_pkg and pinned_lru_page_buffer_pool_defines.svh
`include "pinned_lru_page_buffer_pool_defines.svh"

module plbp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [plbp_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);

    // held result stays offered
    `PLBP_CHECK_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    // an accepted item makes the block busy: ready is low after an accept
    `PLBP_CHECK_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
    // status code in range
    `PLBP_CHECK(a_status, m_axis_tvalid,
        m_axis_tdata[2:0] != 3'd7, "status out of range")
    // only write-back results come before the final result
    `PLBP_CHECK(a_mid_wb, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[8], "non-final result without write-back")
    // write-back fields are zero when no write-back is requested
    `PLBP_CHECK(a_wb_zero, m_axis_tvalid && !m_axis_tdata[8],
        m_axis_tdata[46:9] == '0, "stray write-back fields")

endmodule

bind pinned_lru_page_buffer_pool plbp_checker u_plbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/tb_pinned_lru_page_buffer_pool.sv
// stream testbench for the pinned lru page buffer pool: directed then random operations
// keeps its own slot table, recency and free orders to predict every result item
// depends on plbp_pkg and the pinned_lru_page_buffer_pool rtl
module tb_pinned_lru_page_buffer_pool;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int PIN_LIMIT = 255;
    localparam logic [plbp_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [plbp_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic                          barrier;
        logic [plbp_pkg::ACTION_W-1:0] action;
        logic [plbp_pkg::FILE_W-1:0]   file_id;
        logic [plbp_pkg::PAGE_W-1:0]   page;
        logic                          all_pages;
        logic                          shared;
    } op_t;

    typedef struct {
        logic [plbp_pkg::STATUS_W-1:0] status;
        logic [plbp_pkg::SLOT_W-1:0]   slot;
        logic                          fetch;
        logic                          wb_valid;
        logic [plbp_pkg::FILE_W-1:0]   wb_file;
        logic [plbp_pkg::PAGE_W-1:0]   wb_page;
        logic [plbp_pkg::SLOT_W-1:0]   wb_slot;
        logic                          last;
    } res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [plbp_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [plbp_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    op_t  pending_ops[$];
    res_t expected_results[$];
    op_t  op_on_bus;
    bit   op_taken;
    int   errors = 0;
    int   ops_accepted = 0;
    bit   long_hold_done = 0;

    // shadow pool state
    logic                        pool_valid[SLOTS];
    logic [plbp_pkg::FILE_W-1:0] pool_file[SLOTS];
    logic [plbp_pkg::PAGE_W-1:0] pool_page[SLOTS];
    int                          pool_pins[SLOTS];
    logic                        pool_dirty[SLOTS];
    int                          lru_list[$];
    int                          free_list[$];

    always #10 aclk = ~aclk;

    pinned_lru_page_buffer_pool dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    function automatic void lru_drop(int s);
        foreach (lru_list[i])
            if (lru_list[i] == s) begin
                lru_list.delete(i);
                return;
            end
    endfunction

    function automatic void lru_touch(int s);
        lru_drop(s);
        lru_list.insert(0, s);
    endfunction

    function automatic void push_result(logic [plbp_pkg::STATUS_W-1:0] st, int slot,
                                        bit fetch, bit wbv,
                                        logic [plbp_pkg::FILE_W-1:0] wbf,
                                        logic [plbp_pkg::PAGE_W-1:0] wbp,
                                        int wbs, bit last);
        res_t r;
        r.status = st; r.slot = plbp_pkg::SLOT_W'(slot); r.fetch = fetch;
        r.wb_valid = wbv; r.wb_file = wbf; r.wb_page = wbp;
        r.wb_slot = plbp_pkg::SLOT_W'(wbs); r.last = last;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // single final result with no write-back
    function automatic void push_final(logic [plbp_pkg::STATUS_W-1:0] st, int slot);
        push_result(st, slot, 1'b0, 1'b0, '0, '0, 0, 1'b1);
    endfunction

    // works out the result items of one operation and updates the shadow pool
    function automatic void predict_pool_op(op_t op);
        int hit = -1;
        int s = -1;
        bit wbv = 1'b0;
        logic [plbp_pkg::FILE_W-1:0] wbf = '0;
        logic [plbp_pkg::PAGE_W-1:0] wbp = '0;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && pool_valid[i] && pool_file[i] == op.file_id
                    && pool_page[i] == op.page)
                hit = i;
        case (op.action)
            plbp_pkg::ACT_FETCH_PIN, plbp_pkg::ACT_ALLOCATE: begin
                if (hit >= 0) begin
                    if (op.action == plbp_pkg::ACT_ALLOCATE)
                        push_final(plbp_pkg::ST_ALREADY_RESID, hit);
                    else if (!op.shared && pool_pins[hit] > 0)
                        push_final(plbp_pkg::ST_PINNED_CONFL, hit);
                    else begin
                        if (pool_pins[hit] < PIN_LIMIT)
                            pool_pins[hit]++;
                        lru_touch(hit);
                        push_final(plbp_pkg::ST_OK, hit);
                    end
                    return;
                end
                // victim choice: free slot first, else least recent unpinned
                if (free_list.size() > 0) begin
                    s = free_list[0];
                    free_list.delete(0);
                end else begin
                    for (int i = lru_list.size() - 1; i >= 0 && s < 0; i--)
                        if (pool_pins[lru_list[i]] == 0)
                            s = lru_list[i];
                    if (s >= 0 && pool_valid[s] && pool_dirty[s]) begin
                        wbv = 1'b1; wbf = pool_file[s]; wbp = pool_page[s];
                    end
                end
                if (s < 0) begin
                    push_final(plbp_pkg::ST_NO_VICTIM, 0);
                    return;
                end
                lru_touch(s);
                pool_valid[s] = 1; pool_file[s] = op.file_id; pool_page[s] = op.page;
                pool_pins[s] = 1; pool_dirty[s] = 0;
                push_result(plbp_pkg::ST_OK, s, op.action == plbp_pkg::ACT_FETCH_PIN,
                            wbv, wbf, wbp, wbv ? s : 0, 1'b1);
            end
            plbp_pkg::ACT_MARK_DIRTY: begin
                if (hit < 0) begin
                    push_final(plbp_pkg::ST_NOT_RESIDENT, 0);
                end else begin
                    pool_dirty[hit] = 1;
                    lru_touch(hit);
                    push_final(plbp_pkg::ST_OK, hit);
                end
            end
            plbp_pkg::ACT_UNPIN: begin
                if (hit < 0)
                    push_final(plbp_pkg::ST_NOT_RESIDENT, 0);
                else if (pool_pins[hit] == 0)
                    push_final(plbp_pkg::ST_NOT_PINNED, hit);
                else begin
                    pool_pins[hit]--;
                    if (pool_pins[hit] == 0)
                        lru_touch(hit);
                    push_final(plbp_pkg::ST_OK, hit);
                end
            end
            plbp_pkg::ACT_FLUSH_FILE: begin
                // walk by index, stop at the first pinned slot of the file
                for (int i = 0; i < SLOTS; i++) begin
                    if (!pool_valid[i] || pool_file[i] != op.file_id)
                        continue;
                    if (pool_pins[i] > 0) begin
                        push_final(plbp_pkg::ST_FLUSH_PINNED, i);
                        return;
                    end
                    if (pool_dirty[i]) begin
                        push_result(plbp_pkg::ST_OK, i, 1'b0, 1'b1, pool_file[i],
                                    pool_page[i], i, 1'b0);
                        pool_dirty[i] = 0;
                    end
                    pool_valid[i] = 0;
                    lru_drop(i);
                    free_list.insert(0, i);
                end
                push_final(plbp_pkg::ST_OK, 0);
            end
            plbp_pkg::ACT_FORCE_WB: begin
                // most recent first, write back own page of each dirty match
                foreach (lru_list[i]) begin
                    s = lru_list[i];
                    if (pool_valid[s] && pool_file[s] == op.file_id &&
                        (op.all_pages || pool_page[s] == op.page) && pool_dirty[s]) begin
                        push_result(plbp_pkg::ST_OK, s, 1'b0, 1'b1, pool_file[s],
                                    pool_page[s], s, 1'b0);
                        pool_dirty[s] = 0;
                    end
                end
                push_final(plbp_pkg::ST_OK, 0);
            end
            default: push_final(plbp_pkg::ST_OK, 0);
        endcase
    endfunction

    task automatic queue_op(logic [plbp_pkg::ACTION_W-1:0] act,
                            logic [plbp_pkg::FILE_W-1:0] f,
                            logic [plbp_pkg::PAGE_W-1:0] p, logic all_p, logic shr);
        op_t op;
        op.barrier = 0; op.action = act; op.file_id = f; op.page = p;
        op.all_pages = all_p; op.shared = shr;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic queue_barrier();
        op_t op;
        op = '{1'b1, plbp_pkg::ACT_FETCH_PIN, '0, '0, 1'b0, 1'b0};
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // random operation over a small working set so hits, evictions and no_victim occur
    task automatic queue_random_op();
        int r;
        logic [plbp_pkg::ACTION_W-1:0] act;
        logic [plbp_pkg::FILE_W-1:0] f;
        logic [plbp_pkg::PAGE_W-1:0] p;
        r = $urandom_range(99);
        if (r < 30) act = plbp_pkg::ACT_FETCH_PIN;
        else if (r < 40) act = plbp_pkg::ACT_ALLOCATE;
        else if (r < 55) act = plbp_pkg::ACT_MARK_DIRTY;
        else if (r < 78) act = plbp_pkg::ACT_UNPIN;
        else if (r < 84) act = plbp_pkg::ACT_FLUSH_FILE;
        else if (r < 95) act = plbp_pkg::ACT_FORCE_WB;
        else act = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
        case ($urandom_range(3))
            0: f = 10'd0;
            1: f = 10'h3ff;
            2: f = 10'd5;
            default: f = ($urandom_range(9) == 0) ?
                         plbp_pkg::FILE_W'($urandom_range(1023)) : 10'h2aa;
        endcase
        case ($urandom_range(5))
            0: p = 24'd0;
            1: p = 24'hffffff;
            2: p = 24'h555555;
            3: p = 24'haaaaaa;
            4: p = 24'd7;
            default: p = ($urandom_range(7) == 0) ?
                         plbp_pkg::PAGE_W'($urandom_range(24'hffffff)) : 24'd1;
        endcase
        queue_op(act, f, p, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // driver: offers the next pending item at the falling edge
    int  send_gap = 0;
    bit  send_gaps_on = 1;
    int  send_count = 0;
    always @(negedge aclk) begin
        logic nxt_valid;
        op_t  op;
        nxt_valid = s_axis_tvalid;
        if (aresetn) begin
            if (!s_axis_tvalid || op_taken) begin
                nxt_valid = 0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0) begin
                    if (pending_ops[0].barrier) begin
                        if (expected_results.size() == 0 && !op_taken)
                            pending_ops.delete(0);
                    end else begin
                        op = pending_ops[0];
                        pending_ops.delete(0);
                        op_on_bus <= op;
                        s_axis_tdata <= {1'b0, op.shared, op.all_pages, op.page,
                                         op.file_id, op.action};
                        nxt_valid = 1;
                        send_count++;
                        if (send_count % 50 == 0)
                            send_gaps_on = 1'($urandom_range(1));
                        send_gap = send_gaps_on ? $urandom_range(3) : 0;
                    end
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // receiver: random stalls, plus one long hold to back up the input
    int  recv_gap = 0;
    int  long_hold = 0;
    bit  recv_gaps_on = 1;
    int  recv_count = 0;
    bit  res_taken;
    always @(negedge aclk) begin
        logic nxt_ready;
        nxt_ready = m_axis_tready;
        if (aresetn) begin
            if (!long_hold_done && ops_accepted >= 120) begin
                long_hold_done = 1;
                long_hold = 300;
            end
            if (long_hold > 0) begin
                long_hold--;
                nxt_ready = 0;
            end else if (res_taken || !m_axis_tready) begin
                if (res_taken) begin
                    recv_count++;
                    if (recv_count % 40 == 0)
                        recv_gaps_on = 1'($urandom_range(1));
                    recv_gap = recv_gaps_on ? $urandom_range(3) : 0;
                end
                if (recv_gap > 0) begin
                    recv_gap--;
                    nxt_ready = 0;
                end else begin
                    nxt_ready = 1;
                end
            end
        end
        m_axis_tready <= nxt_ready;
    end

    // monitor: accepts items on both channels at the rising edge
    always @(posedge aclk) begin
        res_t exp_r;
        op_taken = aresetn && s_axis_tvalid && s_axis_tready;
        res_taken = aresetn && m_axis_tvalid && m_axis_tready;
        if (op_taken) begin
            predict_pool_op(op_on_bus);
            ops_accepted++;
        end
        if (res_taken) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                if (m_axis_tdata[2:0] !== exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[6:3] !== exp_r.slot) begin
                    $error("slot_index: expected %0d actual %0d", exp_r.slot, m_axis_tdata[6:3]);
                    errors++;
                end
                if (m_axis_tdata[7] !== exp_r.fetch) begin
                    $error("fetch_needed: expected %b actual %b", exp_r.fetch, m_axis_tdata[7]);
                    errors++;
                end
                if (m_axis_tdata[8] !== exp_r.wb_valid) begin
                    $error("writeback_valid: expected %b actual %b", exp_r.wb_valid,
                           m_axis_tdata[8]);
                    errors++;
                end
                if (m_axis_tdata[18:9] !== exp_r.wb_file) begin
                    $error("writeback_file: expected %0d actual %0d", exp_r.wb_file,
                           m_axis_tdata[18:9]);
                    errors++;
                end
                if (m_axis_tdata[42:19] !== exp_r.wb_page) begin
                    $error("writeback_page: expected %h actual %h", exp_r.wb_page,
                           m_axis_tdata[42:19]);
                    errors++;
                end
                if (m_axis_tdata[46:43] !== exp_r.wb_slot) begin
                    $error("writeback_slot: expected %0d actual %0d", exp_r.wb_slot,
                           m_axis_tdata[46:43]);
                    errors++;
                end
                if (m_axis_tlast !== exp_r.last) begin
                    $error("last: expected %b actual %b", exp_r.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            pool_valid[i] = 0; pool_file[i] = '0; pool_page[i] = '0;
            pool_pins[i] = 0; pool_dirty[i] = 0;
            free_list.insert(free_list.size(), i);
        end
        // basic hits, misses and every status except no victim
        queue_op(plbp_pkg::ACT_FETCH_PIN, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_FETCH_PIN, 10'd0, 24'd0, 1'b1, 1'b0);
        queue_op(plbp_pkg::ACT_FETCH_PIN, 10'd0, 24'd0, 1'b0, 1'b1);
        queue_op(plbp_pkg::ACT_ALLOCATE, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_ALLOCATE, 10'h3ff, 24'hffffff, 1'b1, 1'b1);
        queue_op(plbp_pkg::ACT_MARK_DIRTY, 10'd3, 24'd3, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_MARK_DIRTY, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_MARK_DIRTY, 10'h3ff, 24'hffffff, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_UNPIN, 10'd3, 24'd3, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_UNPIN, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_UNPIN, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_UNPIN, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_FORCE_WB, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_FORCE_WB, 10'h3ff, 24'd0, 1'b1, 1'b0);
        queue_op(plbp_pkg::ACT_MARK_DIRTY, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_FLUSH_FILE, 10'h3ff, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_FLUSH_FILE, 10'd0, 24'd0, 1'b0, 1'b0);
        queue_op(ACT_SPARE_LO, 10'h155, 24'h123456, 1'b1, 1'b1);
        queue_op(ACT_SPARE_HI, 10'h2aa, 24'hedcba9, 1'b0, 1'b0);
        queue_barrier();
        // fill every slot pinned: no victim, then a dirty eviction
        for (int i = 0; i < SLOTS; i++)
            queue_op(plbp_pkg::ACT_FETCH_PIN, 10'd9, plbp_pkg::PAGE_W'(i), 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_FETCH_PIN, 10'd9, 24'd100, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_ALLOCATE, 10'd9, 24'd101, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_FLUSH_FILE, 10'd9, 24'd0, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_MARK_DIRTY, 10'd9, 24'd4, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_UNPIN, 10'd9, 24'd4, 1'b0, 1'b0);
        queue_op(plbp_pkg::ACT_FETCH_PIN, 10'd9, 24'd100, 1'b0, 1'b0);
        // pin count saturation on one page
        for (int i = 0; i < PIN_LIMIT + 2; i++)
            queue_op(plbp_pkg::ACT_FETCH_PIN, 10'd9, 24'd0, 1'b0, 1'b1);
        for (int i = 0; i < 3; i++)
            queue_op(plbp_pkg::ACT_UNPIN, 10'd9, 24'd0, 1'b0, 1'b0);
        for (int i = 0; i < SLOTS; i++)
            queue_op(plbp_pkg::ACT_UNPIN, 10'd9, plbp_pkg::PAGE_W'(i), 1'b0, 1'b0);
        queue_barrier();
        for (int i = 0; i < 55; i++) begin
            queue_random_op();
            if (i == 30)
                queue_barrier();
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (pending_ops.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_pinned_lru_page_buffer_pool: done, clean");
        else
            $display("tb_pinned_lru_page_buffer_pool: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb_pinned_lru_page_buffer_pool: done, errors");
        $finish;
    end

endmodule
